>>> rtl/chct_pkg.sv
// Shared types, constants and codes for the character-code hash table.
`timescale 1ns / 1ps
`default_nettype none
package chct_pkg;

	localparam int NUM_BUCKETS  = 4673;
	localparam int POOL_ENTRIES = 1024;

	localparam int BKT_W  = $clog2(NUM_BUCKETS);
	localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
	localparam int PIDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int KEY_W  = 24;
	localparam int VAL_W  = 16;

	// Hash reduction: shift the signed product up to non-negative, then subtract.
	localparam int PROD_MAX   = 16384;
	localparam int HASH_OFS_K = (PROD_MAX + NUM_BUCKETS - 1) / NUM_BUCKETS;
	localparam int HASH_OFS   = HASH_OFS_K * NUM_BUCKETS;
	localparam int HASH_SPAN  = PROD_MAX + HASH_OFS;
	localparam int HASH_W     = $clog2(HASH_SPAN + 1) + 1;
	localparam int HASH_QMAX  = HASH_SPAN / NUM_BUCKETS;
	localparam int SEL_W      = $clog2(HASH_QMAX + 1);

	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1) + 1;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_INSERTED  = 3'd2;
	localparam logic [2:0] ST_SKIPPED   = 3'd3;
	localparam logic [2:0] ST_POOL_FULL = 3'd4;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  key_byte0;
		logic [7:0]  key_byte1;
		logic [7:0]  key_byte2;
		logic [15:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] found_value;
	} out_item_t;

	typedef struct packed {
		logic             opcode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [BKT_W-1:0] bucket;
	} job_t;

endpackage
`default_nettype wire

>>> rtl/chained_hash_char_to_index.sv
// Top level: hash front end, table engine and result register.
// Path: an item settled at the bucket head passes the hash stages s1 and s2, the job
// queue, the head read from S_IDLE, the head check in S_HEAD and the result register;
// each pool entry walked adds a step in S_POOL.
// Flow: the table engine holds one item at a time; chain length and a stalled
// result output slow it. Reset: arst_n clears control; a sweep then empties every one
// of the 4673 bucket heads, items queue meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_char_to_index (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire chct_pkg::in_item_t  in_item,
	output logic                     empty,
	input  wire logic                pop,
	output chct_pkg::out_item_t      out_item
);

	logic                job_valid, job_pop, res_valid, res_ready, out_valid_q;
	chct_pkg::job_t      job;
	chct_pkg::out_item_t res, out_item_q;

	chct_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.job_valid, .job, .job_pop
	);

	chct_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_pop,
		.res_valid, .res, .res_ready
	);

	assign res_ready = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_item_q <= res;
	end

	assign empty    = !out_valid_q;
	assign out_item = out_item_q;

endmodule
`default_nettype wire

>>> rtl/chct_front.sv
// Front end: hash pipeline and job queue feeding the table engine.
`timescale 1ns / 1ps
`default_nettype none
module chct_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire chct_pkg::in_item_t in_item,
	output logic                    job_valid,
	output chct_pkg::job_t          job,
	input  wire logic               job_pop
);

	logic                                v_s1, v_s2;
	chct_pkg::in_item_t                  item_s1;
	logic signed [15:0]                  prod_s1;
	chct_pkg::job_t                      job_s2;
	chct_pkg::job_t                      fq_q [chct_pkg::FQ_DEPTH];
	logic [chct_pkg::FQ_PTR_W-1:0]       wp_q, rp_q;
	logic [chct_pkg::FQ_CNT_W-1:0]       cnt_q;
	logic [chct_pkg::HASH_W-1:0]         r;
	logic [chct_pkg::SEL_W-1:0]          sel;
	logic [chct_pkg::BKT_W-1:0]          bucket;
	logic                                accept;

	// Count items still in the hash stages so the queue can never overflow.
	assign full = (cnt_q + chct_pkg::FQ_CNT_W'(v_s1) + chct_pkg::FQ_CNT_W'(v_s2))
		>= chct_pkg::FQ_CNT_W'(chct_pkg::FQ_DEPTH);
	assign accept = push && !full;

	always_comb begin
		r = chct_pkg::HASH_W'($signed({{(chct_pkg::HASH_W-16){prod_s1[15]}}, prod_s1})
			+ $signed(chct_pkg::HASH_W'(chct_pkg::HASH_OFS)));
		sel = '0;
		for (int j = 1; j <= chct_pkg::HASH_QMAX; j++) begin
			if (r >= chct_pkg::HASH_W'(j * chct_pkg::NUM_BUCKETS))
				sel = sel + chct_pkg::SEL_W'(1);
		end
		bucket = chct_pkg::BKT_W'(r - chct_pkg::HASH_W'(sel)
			* chct_pkg::HASH_W'(chct_pkg::NUM_BUCKETS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		prod_s1 <= $signed(in_item.key_byte1) * $signed(in_item.key_byte2);
		job_s2.opcode <= item_s1.opcode;
		job_s2.key    <= {item_s1.key_byte0, item_s1.key_byte1, item_s1.key_byte2};
		job_s2.value  <= item_s1.entry_value;
		job_s2.bucket <= bucket;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (v_s2)
				wp_q <= wp_q + chct_pkg::FQ_PTR_W'(1);
			if (job_pop)
				rp_q <= rp_q + chct_pkg::FQ_PTR_W'(1);
			cnt_q <= cnt_q + chct_pkg::FQ_CNT_W'(v_s2) - chct_pkg::FQ_CNT_W'(job_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2)
			fq_q[wp_q] <= job_s2;
	end

	assign job_valid = (cnt_q != '0);
	assign job       = fq_q[rp_q];

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= chct_pkg::FQ_CNT_W'(chct_pkg::FQ_DEPTH))
		else $error("job queue overflow");
	ap_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job queue popped while empty");
	ap_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !v_s1)
		else $error("item entered while full");

endmodule
`default_nettype wire

>>> rtl/chct_back.sv
// Table engine: head and pool memories, chain walk, insert and lookup.
`timescale 1ns / 1ps
`default_nettype none
module chct_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire chct_pkg::job_t job,
	output logic                job_pop,
	output logic                res_valid,
	output chct_pkg::out_item_t res,
	input  wire logic           res_ready
);

	typedef struct packed {
		logic                          used;
		logic [chct_pkg::KEY_W-1:0]    key;
		logic [chct_pkg::VAL_W-1:0]    value;
		logic [chct_pkg::LINK_W-1:0]   next;
	} head_t;

	typedef struct packed {
		logic [chct_pkg::KEY_W-1:0]    key;
		logic [chct_pkg::VAL_W-1:0]    value;
		logic [chct_pkg::LINK_W-1:0]   next;
	} pool_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HEAD  = 5'b00100,
		S_POOL  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                          state_q, state_d;
	head_t                           hmem [chct_pkg::NUM_BUCKETS];
	pool_t                           pmem [chct_pkg::POOL_ENTRIES];
	head_t                           hd_rdata_q, hd_wdata;
	pool_t                           pl_rdata_q, pl_wdata;
	logic                            hd_we, hd_re, pl_we, pl_re;
	logic [chct_pkg::BKT_W-1:0]      hd_addr;
	logic [chct_pkg::PIDX_W-1:0]     pl_waddr, pl_raddr;
	logic [chct_pkg::BKT_W-1:0]      clr_q;
	logic [chct_pkg::LINK_W-1:0]     fill_q;
	logic                            fill_inc;
	chct_pkg::job_t                  job_q;
	logic [chct_pkg::PIDX_W-1:0]     cur_q, cur_d;
	logic [2:0]                      st_q, st_d;
	logic [chct_pkg::VAL_W-1:0]      val_q, val_d;
	logic                            finish;
	logic [chct_pkg::LINK_W-1:0]     fill_link;

	assign fill_link = fill_q + chct_pkg::LINK_W'(1);

	always_comb begin
		state_d  = state_q;
		hd_we    = 1'b0;
		hd_re    = 1'b0;
		hd_addr  = job_q.bucket;
		hd_wdata = hd_rdata_q;
		pl_we    = 1'b0;
		pl_re    = 1'b0;
		pl_waddr = chct_pkg::PIDX_W'(fill_q);
		pl_wdata = '{key: job_q.key, value: job_q.value, next: '0};
		pl_raddr = cur_q;
		cur_d    = cur_q;
		fill_inc = 1'b0;
		finish   = 1'b0;
		st_d     = st_q;
		val_d    = '0;
		job_pop  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				hd_we    = 1'b1;
				hd_addr  = clr_q;
				hd_wdata = '0;
				if (clr_q == chct_pkg::BKT_W'(chct_pkg::NUM_BUCKETS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					hd_re   = 1'b1;
					hd_addr = job.bucket;
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				cur_d    = chct_pkg::PIDX_W'(hd_rdata_q.next - chct_pkg::LINK_W'(1));
				pl_raddr = cur_d;
				if (job_q.opcode == chct_pkg::OP_LOOKUP) begin
					if (!hd_rdata_q.used) begin
						finish = 1'b1;
						st_d   = chct_pkg::ST_NOT_FOUND;
					end else if (hd_rdata_q.key == job_q.key) begin
						finish = 1'b1;
						st_d   = chct_pkg::ST_FOUND;
						val_d  = hd_rdata_q.value;
					end else if (hd_rdata_q.next == '0) begin
						finish = 1'b1;
						st_d   = chct_pkg::ST_NOT_FOUND;
					end else begin
						pl_re   = 1'b1;
						state_d = S_POOL;
					end
				end else if (!hd_rdata_q.used) begin
					hd_we    = 1'b1;
					hd_wdata = '{used: 1'b1, key: job_q.key, value: job_q.value, next: '0};
					finish   = 1'b1;
					st_d     = chct_pkg::ST_INSERTED;
				end else if (hd_rdata_q.value == job_q.value) begin
					finish = 1'b1;
					st_d   = chct_pkg::ST_SKIPPED;
				end else if (fill_q == chct_pkg::LINK_W'(chct_pkg::POOL_ENTRIES)) begin
					finish = 1'b1;
					st_d   = chct_pkg::ST_POOL_FULL;
				end else begin
					pl_we = 1'b1;
					if (hd_rdata_q.next == '0) begin
						hd_we         = 1'b1;
						hd_wdata.next = fill_link;
						fill_inc      = 1'b1;
						finish        = 1'b1;
						st_d          = chct_pkg::ST_INSERTED;
					end else begin
						pl_re   = 1'b1;
						state_d = S_POOL;
					end
				end
			end
			S_POOL: begin
				cur_d    = chct_pkg::PIDX_W'(pl_rdata_q.next - chct_pkg::LINK_W'(1));
				pl_raddr = cur_d;
				if (job_q.opcode == chct_pkg::OP_LOOKUP) begin
					if (pl_rdata_q.key == job_q.key) begin
						finish = 1'b1;
						st_d   = chct_pkg::ST_FOUND;
						val_d  = pl_rdata_q.value;
					end else if (pl_rdata_q.next == '0) begin
						finish = 1'b1;
						st_d   = chct_pkg::ST_NOT_FOUND;
					end else begin
						pl_re = 1'b1;
					end
				end else if (pl_rdata_q.next == '0) begin
					// Link the new entry behind the current tail.
					pl_we         = 1'b1;
					pl_waddr      = cur_q;
					pl_wdata      = pl_rdata_q;
					pl_wdata.next = fill_link;
					fill_inc      = 1'b1;
					finish        = 1'b1;
					st_d          = chct_pkg::ST_INSERTED;
				end else begin
					pl_re = 1'b1;
				end
			end
			S_RESP: begin
				if (res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (finish)
			state_d = S_RESP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + chct_pkg::BKT_W'(1);
			if (fill_inc)
				fill_q <= fill_link;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job;
		cur_q <= cur_d;
		if (finish) begin
			st_q  <= st_d;
			val_q <= val_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hd_we)
			hmem[hd_addr] <= hd_wdata;
		if (hd_re)
			hd_rdata_q <= hmem[hd_addr];
	end

	always_ff @(posedge clk) begin
		if (pl_we)
			pmem[pl_waddr] <= pl_wdata;
		if (pl_re)
			pl_rdata_q <= pmem[pl_raddr];
	end

	assign res_valid       = (state_q == S_RESP);
	assign res.status      = st_q;
	assign res.found_value = val_q;

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= chct_pkg::LINK_W'(chct_pkg::POOL_ENTRIES))
		else $error("pool fill beyond capacity");
	ap_no_job_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !job_pop)
		else $error("job taken during clear");
	ap_fill_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		fill_inc |-> job_q.opcode == chct_pkg::OP_INSERT)
		else $error("pool grew on lookup");
	ap_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(st_q))
		else $error("result dropped before taken");

endmodule
`default_nettype wire
